// ----- sv/rgbe_rle_pkg.sv -----
// Shared types and constants of the RGBE run-length scanline decoder.
package rgbe_rle_pkg;

  // Result status codes.
  localparam logic [1:0] ST_FILL    = 2'd0;
  localparam logic [1:0] ST_BADHDR  = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;

  // Row header position codes; HP_DATA means the row body is being decoded.
  localparam logic [2:0] HP_MAGIC0   = 3'd0;
  localparam logic [2:0] HP_MAGIC1   = 3'd1;
  localparam logic [2:0] HP_WIDTH_HI = 3'd2;
  localparam logic [2:0] HP_WIDTH_LO = 3'd3;
  localparam logic [2:0] HP_DATA     = 3'd4;

  // Byte values with a meaning in the stream.
  localparam logic [7:0] HDR_MAGIC = 8'd2;
  localparam logic [7:0] RUN_BASE  = 8'h80;

  // Configuration register indexes.
  localparam logic REG_SCAN_WIDTH   = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // One decoded result.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] row;
    logic [16:0] offset;
    logic [6:0]  length;
    logic [7:0]  value;
    logic        row_done;
    logic        image_done;
  } rgbe_res_t;

endpackage

// ----- sv/rgbe_scanline_rle_decoder.sv -----
// Top level of the RGBE run-length scanline decoder with its register port.
// Latency: a result appears on out_* in the cycle after the byte that causes it.
// Throughput: one input byte per cycle while no held result is stalled by out_tready;
// the output register lets a new byte in while the held result is taken in the same cycle.
// Reset (rst_n low, synchronous): decoder state cleared, registers scan_width = 1
// and image_height = 1, output register empty.
module rgbe_scanline_rle_decoder
  import rgbe_rle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] row, [32:16] offset, [39:33] length,
                                  // [47:40] value
  output logic        out_tlast,  // row_done
  output logic [2:0]  out_tuser,  // [1:0] status, [2] image_done
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [14:0] scan_width_r;
  logic [15:0] image_height_r;
  logic        cfg_wr;
  logic        in_fire;
  logic        res_valid;
  rgbe_res_t   res;
  logic        out_valid_r, out_valid_nxt;
  rgbe_res_t   out_res_r;

  // Register port: writes complete in the access phase, reads are immediate.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_width_r   <= 15'd1;
      image_height_r <= 16'd1;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_SCAN_WIDTH) begin
        scan_width_r <= cfg_pwdata[14:0];
      end else begin
        image_height_r <= cfg_pwdata[15:0];
      end
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_SCAN_WIDTH:   cfg_prdata = {17'd0, scan_width_r};
      REG_IMAGE_HEIGHT: cfg_prdata = {16'd0, image_height_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // A beat is taken whenever the output register is free or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  rgbe_rle_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_fire),
    .data_byte    (in_tdata),
    .scan_width   (scan_width_r),
    .image_height (image_height_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Output register.
  always_comb begin
    if (in_fire && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.value, out_res_r.length, out_res_r.offset, out_res_r.row};
  assign out_tlast  = out_res_r.row_done;
  assign out_tuser  = {out_res_r.image_done, out_res_r.status};

  // An error result is the last one the decoder ever produces.
  a_error_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && (out_tuser[1:0] != ST_FILL)) |=> !out_tvalid)
    else $error("result beat after an error beat");

  // The image ends only on a write that also ends its row.
  a_image_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> out_tlast)
    else $error("image_done without row_done");

  // Error results never mark the end of a row or the image.
  a_error_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[1:0] != ST_FILL)) |-> (!out_tlast && !out_tuser[2]))
    else $error("error beat flagged as row or image end");

endmodule

// ----- sv/rgbe_rle_core.sv -----
// Decoder state and per-byte decode logic of the RGBE scanline decoder.
module rgbe_rle_core
  import rgbe_rle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic [14:0] scan_width,
  input  logic [15:0] image_height,
  output logic        res_valid,
  output rgbe_res_t   res
);

  logic [2:0]  header_pos_r,  header_pos_nxt;
  logic [7:0]  width_hi_r,    width_hi_nxt;
  logic [16:0] row_offset_r,  row_offset_nxt;
  logic [7:0]  literal_left_r, literal_left_nxt;
  logic        run_waiting_r, run_waiting_nxt;
  logic [6:0]  run_length_r,  run_length_nxt;
  logic [15:0] row_index_r,   row_index_nxt;
  logic        error_r,       error_nxt;
  logic        finished_r,    finished_nxt;

  logic [16:0] row_total;
  logic [6:0]  fill_len;
  logic [17:0] fill_end;
  logic        fill_over;
  logic        fill_hit;
  logic        last_row;
  logic [15:0] hdr_width;

  // Fill geometry shared by runs and literals.
  assign row_total = {scan_width, 2'b00};
  assign fill_len  = run_waiting_r ? run_length_r : 7'd1;
  assign fill_end  = {1'b0, row_offset_r} + {11'd0, fill_len};
  assign fill_over = fill_end > {1'b0, row_total};
  assign fill_hit  = fill_end == {1'b0, row_total};
  assign last_row  = row_index_r == (image_height - 16'd1);
  assign hdr_width = {width_hi_r, data_byte};

  // Next state and result for one accepted byte.
  always_comb begin
    header_pos_nxt   = header_pos_r;
    width_hi_nxt     = width_hi_r;
    row_offset_nxt   = row_offset_r;
    literal_left_nxt = literal_left_r;
    run_waiting_nxt  = run_waiting_r;
    run_length_nxt   = run_length_r;
    row_index_nxt    = row_index_r;
    error_nxt        = error_r;
    finished_nxt     = finished_r;
    res_valid        = 1'b0;
    res.status       = ST_FILL;
    res.row          = row_index_r;
    res.offset       = row_offset_r;
    res.length       = fill_len;
    res.value        = data_byte;
    res.row_done     = 1'b0;
    res.image_done   = 1'b0;

    if (step && !error_r && !finished_r) begin
      unique case (header_pos_r)
        HP_MAGIC0, HP_MAGIC1: begin
          if (data_byte != HDR_MAGIC) begin
            res_valid  = 1'b1;
            res.status = ST_BADHDR;
            res.offset = '0;
            res.length = '0;
            error_nxt  = 1'b1;
          end else begin
            header_pos_nxt = header_pos_r + 3'd1;
          end
        end
        HP_WIDTH_HI: begin
          width_hi_nxt   = data_byte;
          header_pos_nxt = HP_WIDTH_LO;
        end
        HP_WIDTH_LO: begin
          if ((scan_width == '0) || (hdr_width != {1'b0, scan_width})) begin
            res_valid  = 1'b1;
            res.status = ST_BADHDR;
            res.offset = '0;
            res.length = '0;
            error_nxt  = 1'b1;
          end else begin
            header_pos_nxt   = HP_DATA;
            row_offset_nxt   = '0;
            literal_left_nxt = '0;
            run_waiting_nxt  = 1'b0;
            run_length_nxt   = '0;
          end
        end
        default: begin
          if (run_waiting_r || (literal_left_r != '0)) begin
            // A run value byte or a literal byte writes into the row.
            if (run_waiting_r) begin
              run_waiting_nxt = 1'b0;
            end else begin
              literal_left_nxt = literal_left_r - 8'd1;
            end
            res_valid = 1'b1;
            if (fill_over) begin
              res.status = ST_OVERRUN;
              error_nxt  = 1'b1;
            end else if (fill_hit) begin
              res.row_done     = 1'b1;
              res.image_done   = last_row;
              row_offset_nxt   = '0;
              literal_left_nxt = '0;
              run_waiting_nxt  = 1'b0;
              run_length_nxt   = '0;
              header_pos_nxt   = HP_MAGIC0;
              row_index_nxt    = row_index_r + 16'd1;
              finished_nxt     = last_row;
            end else begin
              row_offset_nxt = fill_end[16:0];
            end
          end else if (data_byte > RUN_BASE) begin
            // Run code: the next byte is the run value.
            run_waiting_nxt = 1'b1;
            run_length_nxt  = data_byte[6:0];
          end else begin
            literal_left_nxt = data_byte;
          end
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_pos_r   <= HP_MAGIC0;
      width_hi_r     <= '0;
      row_offset_r   <= '0;
      literal_left_r <= '0;
      run_waiting_r  <= 1'b0;
      run_length_r   <= '0;
      row_index_r    <= '0;
      error_r        <= 1'b0;
      finished_r     <= 1'b0;
    end else begin
      header_pos_r   <= header_pos_nxt;
      width_hi_r     <= width_hi_nxt;
      row_offset_r   <= row_offset_nxt;
      literal_left_r <= literal_left_nxt;
      run_waiting_r  <= run_waiting_nxt;
      run_length_r   <= run_length_nxt;
      row_index_r    <= row_index_nxt;
      error_r        <= error_nxt;
      finished_r     <= finished_nxt;
    end
  end

endmodule

// ----- bench/rgbe_scanline_rle_decoder_tb.sv -----
// Self-checking testbench for the RGBE run-length scanline decoder.
module rgbe_scanline_rle_decoder_tb;
  import rgbe_rle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES = 1600;
  localparam int unsigned REPORT_CAP = 40;

  // Ways the single image of the run is brought to its end.
  typedef enum int unsigned {
    END_IMAGE_DONE,
    END_BAD_MAGIC0,
    END_BAD_MAGIC1,
    END_BAD_WIDTH,
    END_OVERRUN,
    END_ZERO_WIDTH,
    END_SHRINK
  } end_case_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic [2:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rgbe_scanline_rle_decoder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // [7:0] data_byte
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // [15:0] row, [32:16] offset, [39:33] length, [47:40] value
    .out_tlast   (out_tlast),    // row_done
    .out_tuser   (out_tuser),    // [1:0] status, [2] image_done
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Byte stream waiting for the driver and fill writes waiting for the monitor.
  logic [7:0] stream_bytes[$];
  rgbe_res_t  predicted_writes[$];
  int unsigned fed_count = 0;
  int unsigned taken_count = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  // Idling percentages for the sender and the receiver.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned gap_by_phase[4] = '{0, 52, 0, 15};
  int unsigned stall_by_phase[4] = '{0, 0, 52, 15};

  // Decoder copy: registers and decode state, at their reset values.
  logic [14:0] dec_width = 15'd1;
  logic [15:0] dec_height = 16'd1;
  logic [2:0]  dec_hdr_pos = HP_MAGIC0;
  logic [7:0]  dec_width_hi = '0;
  logic [16:0] dec_row_off = '0;
  logic [7:0]  dec_lit_left = '0;
  logic        dec_run_pending = 1'b0;
  logic [6:0]  dec_run_len = '0;
  logic [15:0] dec_row_idx = '0;
  logic        dec_error = 1'b0;
  logic        dec_finished = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  // One fill write of len bytes at the current row position.
  task automatic emit_fill(input int unsigned len, input logic [7:0] val,
                           output rgbe_res_t res);
    int unsigned row_bytes;
    int unsigned end_pos;
    logic        last_row;
    row_bytes = 32'(dec_width) * 4;
    end_pos = 32'(dec_row_off) + len;
    res = '0;
    res.row = dec_row_idx;
    res.offset = dec_row_off;
    res.length = len[6:0];
    res.value = val;
    if (end_pos > row_bytes) begin
      res.status = ST_OVERRUN;
      dec_error = 1'b1;
    end else begin
      res.status = ST_FILL;
      if (end_pos == row_bytes) begin
        last_row = (dec_row_idx == dec_height - 16'd1);
        res.row_done = 1'b1;
        res.image_done = last_row;
        dec_row_off = '0;
        dec_lit_left = '0;
        dec_run_pending = 1'b0;
        dec_run_len = '0;
        dec_hdr_pos = HP_MAGIC0;
        dec_row_idx = dec_row_idx + 16'd1;
        if (last_row) dec_finished = 1'b1;
      end else begin
        dec_row_off = end_pos[16:0];
      end
    end
  endtask

  // Advances the decoder copy by one stream byte.
  task automatic decode_byte(input logic [7:0] b, output bit produced,
                             output rgbe_res_t res);
    logic bad;
    produced = 1'b0;
    res = '0;
    bad = 1'b0;
    if (!dec_error && !dec_finished) begin
      if (dec_hdr_pos != HP_DATA) begin
        case (dec_hdr_pos)
          HP_MAGIC0, HP_MAGIC1: bad = (b != HDR_MAGIC);
          HP_WIDTH_HI: dec_width_hi = b;
          default: bad = (dec_width == '0) || ({dec_width_hi, b} != {1'b0, dec_width});
        endcase
        if (bad) begin
          res.status = ST_BADHDR;
          res.row = dec_row_idx;
          res.value = b;
          produced = 1'b1;
          dec_error = 1'b1;
        end else begin
          dec_hdr_pos = dec_hdr_pos + 3'd1;
          if (dec_hdr_pos == HP_DATA) begin
            dec_row_off = '0;
            dec_lit_left = '0;
            dec_run_pending = 1'b0;
            dec_run_len = '0;
          end
        end
      end else if (dec_run_pending) begin
        dec_run_pending = 1'b0;
        emit_fill(dec_run_len, b, res);
        produced = 1'b1;
      end else if (dec_lit_left != '0) begin
        dec_lit_left = dec_lit_left - 8'd1;
        emit_fill(1, b, res);
        produced = 1'b1;
      end else if (b > RUN_BASE) begin
        dec_run_pending = 1'b1;
        dec_run_len = 7'(b - RUN_BASE);
      end else begin
        dec_lit_left = b;
      end
    end
  endtask

  task automatic report_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
  endtask

  // Sender: presents the next queued byte, holding it until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (stream_bytes.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
        in_tdata <= stream_bytes.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // Monitor: checks result beats, predicts from input beats, runs the watchdog.
  always @(posedge clk) begin : monitor
    rgbe_res_t got;
    rgbe_res_t want;
    rgbe_res_t pred;
    bit        made;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser[1:0], out_tdata[15:0], out_tdata[32:16], out_tdata[39:33],
               out_tdata[47:40], out_tlast, out_tuser[2]};
        if (predicted_writes.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $display("%0t ns: result beat with none expected, got %h", $time, got);
        end else begin
          want = predicted_writes.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_CAP) begin
              if (got.status !== want.status) report_field("status", want.status, got.status);
              if (got.row !== want.row) report_field("row", want.row, got.row);
              if (got.offset !== want.offset) report_field("offset", want.offset, got.offset);
              if (got.length !== want.length) report_field("length", want.length, got.length);
              if (got.value !== want.value) report_field("value", want.value, got.value);
              if (got.row_done !== want.row_done)
                report_field("row_done", want.row_done, got.row_done);
              if (got.image_done !== want.image_done)
                report_field("image_done", want.image_done, got.image_done);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, made, pred);
        if (made) predicted_writes.push_back(pred);
        taken_count++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("** rgbe_scanline_rle_decoder: FAILED **");
          $finish;
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    stream_bytes.push_back(b);
    fed_count++;
  endtask

  task automatic push_header(input logic [15:0] w);
    push_byte(HDR_MAGIC);
    push_byte(HDR_MAGIC);
    push_byte(w[15:8]);
    push_byte(w[7:0]);
  endtask

  // One well-formed row for the current width, with random runs and literals.
  task automatic push_row();
    int unsigned left;
    int unsigned n;
    int unsigned cap;
    push_header({1'b0, dec_width});
    left = 32'(dec_width) * 4;
    while (left > 0) begin
      case ($urandom_range(9, 0))
        0: push_byte(8'h00);
        1, 2, 3, 4: begin
          n = $urandom_range((left < 127) ? left : 127, 1);
          push_byte(RUN_BASE + 8'(n));
          push_byte(8'($urandom));
          left -= n;
        end
        default: begin
          cap = ($urandom_range(3, 0) == 0) ? 128 : 6;
          if (cap > left) cap = left;
          n = $urandom_range(cap, 1);
          push_byte(8'(n));
          repeat (n) push_byte(8'($urandom));
          left -= n;
        end
      endcase
    end
  endtask

  // Waits until every byte is taken and every predicted write has arrived.
  task automatic wait_drained();
    while (fed_count != taken_count || predicted_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write over the APB port; the block is idle whenever this runs.
  task automatic apb_write(input logic reg_idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (reg_idx == REG_SCAN_WIDTH) dec_width = value[14:0];
    else dec_height = value[15:0];
  endtask

  task automatic set_idling(input int unsigned phase);
    gap_pct = gap_by_phase[phase];
    stall_pct = stall_by_phase[phase];
  endtask

  // Stimulus sequence.
  initial begin
    int unsigned start_count;
    int unsigned chunk_start;
    int unsigned left;
    int unsigned n;
    int unsigned r;
    logic [15:0] bad_w;
    end_case_t   ending;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: zero height, then a height change in the middle of a row.
    set_idling(0);
    apb_write(REG_IMAGE_HEIGHT, 32'd0);
    apb_write(REG_SCAN_WIDTH, 32'd1);
    push_header(16'd1);
    wait_drained();
    apb_write(REG_IMAGE_HEIGHT, 32'd65535);
    // Empty literal, one-byte run of zero, two literals, one-byte run.
    push_byte(8'h00);
    push_byte(8'h81);
    push_byte(8'h00);
    push_byte(8'h02);
    push_byte(8'hFF);
    push_byte(8'h55);
    push_byte(8'h81);
    push_byte(8'hAA);
    wait_drained();
    apb_write(REG_SCAN_WIDTH, 32'd32);
    apb_write(REG_IMAGE_HEIGHT, 32'd0);
    // Longest run, then one literal to close the row.
    push_header(16'd32);
    push_byte(8'hFF);
    push_byte(8'h7E);
    push_byte(8'h01);
    push_byte(8'h80);
    wait_drained();

    // Widest header and a 128-byte literal; the width then drops in the middle
    // of the row and a short literal closes the narrower row.
    set_idling(3);
    apb_write(REG_SCAN_WIDTH, 32'd32767);
    push_header(16'h7FFF);
    push_byte(RUN_BASE);
    repeat (128) push_byte(8'($urandom));
    wait_drained();
    apb_write(REG_SCAN_WIDTH, 32'd33);
    push_byte(8'h04);
    repeat (4) push_byte(8'($urandom));
    wait_drained();

    // Random rows in chunks, each chunk with fresh settings.
    start_count = fed_count;
    while (fed_count - start_count < RANDOM_BYTES) begin
      set_idling((fed_count - start_count) * 4 / RANDOM_BYTES);
      r = $urandom_range(19, 0);
      if (r < 14) n = $urandom_range(8, 1);
      else if (r < 19) n = $urandom_range(40, 9);
      else n = $urandom_range(64, 41);
      apb_write(REG_SCAN_WIDTH, n);
      if ($urandom_range(2, 0) == 0) begin
        r = $urandom_range(3, 0);
        if (r == 0) apb_write(REG_IMAGE_HEIGHT, 32'd0);
        else if (r == 1) apb_write(REG_IMAGE_HEIGHT, 32'd65535);
        else apb_write(REG_IMAGE_HEIGHT, $urandom_range(65534, 1000));
      end
      chunk_start = fed_count;
      while (fed_count - chunk_start < 100 + $urandom_range(100, 0)) push_row();
      wait_drained();
    end

    // Closing sequence: the image ends or a sticky error stops it.
    set_idling($urandom_range(3, 0));
    ending = end_case_t'($urandom_range(6, 0));
    case (ending)
      END_IMAGE_DONE: begin
        apb_write(REG_IMAGE_HEIGHT, {16'd0, dec_row_idx + 16'd1});
        push_row();
      end
      END_BAD_MAGIC0: begin
        n = $urandom_range(255, 0);
        if (8'(n) == HDR_MAGIC) n = n + 1;
        push_byte(8'(n));
      end
      END_BAD_MAGIC1: begin
        n = $urandom_range(255, 0);
        if (8'(n) == HDR_MAGIC) n = n + 1;
        push_byte(HDR_MAGIC);
        push_byte(8'(n));
      end
      END_BAD_WIDTH: begin
        bad_w = {1'b0, dec_width} ^ (16'd1 << $urandom_range(15, 0));
        push_header(bad_w);
      end
      END_OVERRUN: begin
        apb_write(REG_SCAN_WIDTH, $urandom_range(31, 1));
        push_header({1'b0, dec_width});
        left = 32'(dec_width) * 4;
        if (left > 1 && $urandom_range(1, 0) == 1) begin
          n = $urandom_range(left - 1, 1);
          push_byte(8'(n));
          repeat (n) push_byte(8'($urandom));
          left -= n;
        end
        n = $urandom_range(127, left + 1);
        push_byte(RUN_BASE + 8'(n));
        push_byte(8'($urandom));
      end
      END_ZERO_WIDTH: begin
        apb_write(REG_SCAN_WIDTH, 32'd0);
        push_header(16'd0);
      end
      default: begin
        // The width shrinks to no more than what the row already holds.
        apb_write(REG_SCAN_WIDTH, 32'd8);
        push_header(16'd8);
        push_byte(8'h90);
        push_byte(8'($urandom));
        wait_drained();
        apb_write(REG_SCAN_WIDTH, $urandom_range(4, 1));
        push_byte(8'h01);
        push_byte(8'($urandom));
      end
    endcase
    // Bytes after the end must be swallowed without results.
    repeat (20) push_byte(8'($urandom));

    stall_pct = 0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("** rgbe_scanline_rle_decoder: PASSED **");
    end else begin
      $display("** rgbe_scanline_rle_decoder: FAILED **");
    end
    $finish;
  end

endmodule
